// File: src/bc3_texture_block_decoder_assert.svh
// Assertion macros for the BC3 block decoder checker.
`ifndef BC3_TEXTURE_BLOCK_DECODER_ASSERT_SVH
`define BC3_TEXTURE_BLOCK_DECODER_ASSERT_SVH

// same-cycle implication
`define BC3_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bc3 decoder check failed");

// next-cycle implication
`define BC3_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bc3 decoder check failed");

`endif

// File: src/bc3_pkg.sv
package bc3_pkg;

   localparam int MaxDimension = 16384;
   localparam int DimRegW      = 15;
   localparam int CoordW       = 14;
   localparam int QueueDepth   = 2;

   localparam logic [DimRegW-1:0] DimReset = 15'd16384;

   // register indexes on the csr port
   localparam logic RegImageWidth  = 1'b0;
   localparam logic RegImageHeight = 1'b1;

   // reciprocal multipliers, exact over the numerator ranges used here
   localparam int DivShift = 14;
   localparam logic [12:0] Div7Mul = 13'd2341;
   localparam logic [12:0] Div5Mul = 13'd3277;
   localparam logic [12:0] Div3Mul = 13'd5462;

   typedef enum logic [1:0] {
      AOP_PASS,
      AOP_DIV7,
      AOP_DIV5
   } alpha_op_type;

   typedef enum logic [1:0] {
      COP_PASS,
      COP_DIV3,
      COP_DIV2
   } color_op_type;

   // channel 2 red, 1 green, 0 blue
   typedef logic [2:0][7:0] rgb_type;

   typedef struct packed {
      logic [7:0]  alpha0;
      logic [7:0]  alpha1;
      logic [47:0] alpha_index;
      rgb_type     color0;
      rgb_type     color1;
      logic        color_greater;
      logic [31:0] color_index;
      logic [11:0] block_column;
      logic [11:0] block_row;
      logic [15:0] texel_mask;
   } bc3_entry_type;

   function automatic logic [7:0] expand5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] expand6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [23:0] prod;
      prod = 24'(x) * 24'(Div7Mul);
      return prod[DivShift +: 8];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [23:0] prod;
      prod = 24'(x) * 24'(Div5Mul);
      return prod[DivShift +: 8];
   endfunction

   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [23:0] prod;
      prod = 24'(x) * 24'(Div3Mul);
      return prod[DivShift +: 8];
   endfunction

endpackage

// File: src/bc3_if.sv
interface bc3_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_low;
   logic [63:0] block_high;
   logic [11:0] block_column;
   logic [11:0] block_row;

   modport source (output valid, block_low, block_high, block_column, block_row,
                   input ready);
   modport sink   (input valid, block_low, block_high, block_column, block_row,
                   output ready);
endinterface

interface bc3_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] pixel_x;
   logic [13:0] pixel_y;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha_value;
   logic        last_texel;

   modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha_value,
                   last_texel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, red, green, blue, alpha_value,
                   last_texel, output ready);
endinterface

// File: src/bc3_front.sv
module bc3_front #(
   parameter int MAX_DIMENSION = bc3_pkg::MaxDimension
) (
   input  logic                   clock,
   input  logic                   reset,
   bc3_req_if.sink                req,
   input  logic                   csr_write_enable,
   input  logic                   csr_index,
   input  logic [bc3_pkg::DimRegW-1:0] csr_write_data,
   output logic                   push_valid,
   input  logic                   push_ready,
   output bc3_pkg::bc3_entry_type push_entry
);

   localparam int LimW = $clog2(MAX_DIMENSION + 1);
   localparam int DimW = (LimW > bc3_pkg::DimRegW) ? LimW : bc3_pkg::DimRegW;
   localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIMENSION);

   logic [bc3_pkg::DimRegW-1:0] width_ff, width_in;
   logic [bc3_pkg::DimRegW-1:0] height_ff, height_in;
   logic [DimW-1:0] width_lim, height_lim;
   logic [3:0]      col_ok, row_ok;
   logic [15:0]     mask;
   logic [15:0]     c0, c1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            bc3_pkg::RegImageWidth:  width_in  = csr_write_data;
            bc3_pkg::RegImageHeight: height_in = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bc3_pkg::DimReset;
         height_ff <= bc3_pkg::DimReset;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign width_lim  = (DimW'(width_ff) > MaxDim) ? MaxDim : DimW'(width_ff);
   assign height_lim = (DimW'(height_ff) > MaxDim) ? MaxDim : DimW'(height_ff);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         col_ok[k] = DimW'({req.block_column, 2'(k)}) < width_lim;
         row_ok[k] = DimW'({req.block_row, 2'(k)}) < height_lim;
      end
      for (int p = 0; p < 16; p++) begin
         mask[p] = col_ok[p % 4] & row_ok[p / 4];
      end
   end

   assign c0 = req.block_high[15:0];
   assign c1 = req.block_high[31:16];

   always_comb begin
      push_entry.alpha0        = req.block_low[7:0];
      push_entry.alpha1        = req.block_low[15:8];
      push_entry.alpha_index   = req.block_low[63:16];
      push_entry.color0        = {bc3_pkg::expand5(c0[15:11]), bc3_pkg::expand6(c0[10:5]),
                                  bc3_pkg::expand5(c0[4:0])};
      push_entry.color1        = {bc3_pkg::expand5(c1[15:11]), bc3_pkg::expand6(c1[10:5]),
                                  bc3_pkg::expand5(c1[4:0])};
      push_entry.color_greater = c0 > c1;
      push_entry.color_index   = req.block_high[63:32];
      push_entry.block_column  = req.block_column;
      push_entry.block_row     = req.block_row;
      push_entry.texel_mask    = mask;
   end

   // wholly clipped blocks are taken and dropped here
   assign req.ready  = push_ready;
   assign push_valid = req.valid && (mask != '0);

endmodule

// File: src/bc3_queue.sv
module bc3_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  bc3_pkg::bc3_entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output bc3_pkg::bc3_entry_type pop_entry
);

   localparam int Depth = bc3_pkg::QueueDepth;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   bc3_pkg::bc3_entry_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != CntW'(Depth);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/bc3_back.sv
module bc3_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  bc3_pkg::bc3_entry_type pop_entry,
   bc3_rsp_if.source              rsp
);

   // sequencer
   logic                   cur_valid_ff, cur_valid_in;
   bc3_pkg::bc3_entry_type cur_ff, cur_in;
   logic [15:0]            rem_ff, rem_in;
   logic [15:0]            low_bit, rem_after;
   logic [3:0]             texel;
   logic                   issue, last_issue;

   // stage A: palette numerators
   logic                  a_valid_ff, a_valid_in;
   logic [13:0]           a_px_ff, a_py_ff;
   logic                  a_last_ff;
   logic [10:0]           a_anum_ff, anum;
   bc3_pkg::alpha_op_type a_aop_ff, aop;
   logic [2:0][9:0]       a_cnum_ff, cnum;
   bc3_pkg::color_op_type a_cop_ff, cop;
   logic                  a_free;

   // stage B: output register
   logic            out_valid_ff, out_valid_in;
   logic [13:0]     out_px_ff, out_py_ff;
   bc3_pkg::rgb_type out_rgb_ff, rgb;
   logic [7:0]      out_alpha_ff, alpha;
   logic            out_last_ff;
   logic            load_b;

   logic [2:0]      ai, wa, wb;
   logic [1:0]      ci;
   logic            alpha_greater;

   assign load_b = !out_valid_ff || rsp.ready;
   assign a_free = !a_valid_ff || load_b;

   // next texel: lowest set bit of what remains
   always_comb begin
      low_bit   = rem_ff & (~rem_ff + 16'd1);
      rem_after = rem_ff & ~low_bit;
      texel     = '0;
      for (int q = 0; q < 16; q++) begin
         if (low_bit[q]) begin
            texel = texel | 4'(q);
         end
      end
   end

   assign issue      = cur_valid_ff && a_free;
   assign last_issue = issue && (rem_after == '0);
   assign pop_ready  = !cur_valid_ff || last_issue;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      priority if (pop_valid && pop_ready) begin
         cur_valid_in = 1'b1;
         cur_in       = pop_entry;
         rem_in       = pop_entry.texel_mask;
      end else if (last_issue) begin
         cur_valid_in = 1'b0;
      end else if (issue) begin
         rem_in = rem_after;
      end
   end

   // alpha palette entry
   always_comb begin
      ai            = cur_ff.alpha_index[3*texel +: 3];
      alpha_greater = cur_ff.alpha0 > cur_ff.alpha1;
      wa            = '0;
      wb            = '0;
      aop           = bc3_pkg::AOP_PASS;
      anum          = '0;
      priority if (ai == 3'd0) begin
         anum = 11'(cur_ff.alpha0);
      end else if (ai == 3'd1) begin
         anum = 11'(cur_ff.alpha1);
      end else if (alpha_greater) begin
         wa   = 3'(4'd8 - {1'b0, ai});
         wb   = ai - 3'd1;
         aop  = bc3_pkg::AOP_DIV7;
         anum = 11'(cur_ff.alpha0) * 11'(wa) + 11'(cur_ff.alpha1) * 11'(wb);
      end else if (ai <= 3'd5) begin
         wa   = 3'(4'd6 - {1'b0, ai});
         wb   = ai - 3'd1;
         aop  = bc3_pkg::AOP_DIV5;
         anum = 11'(cur_ff.alpha0) * 11'(wa) + 11'(cur_ff.alpha1) * 11'(wb);
      end else if (ai == 3'd6) begin
         anum = '0;
      end else begin
         anum = 11'd255;
      end
   end

   // colour palette entry, per channel
   always_comb begin
      ci  = cur_ff.color_index[2*texel +: 2];
      cop = bc3_pkg::COP_PASS;
      for (int ch = 0; ch < 3; ch++) begin
         cnum[ch] = 10'(cur_ff.color0[ch]);
      end
      unique case (ci)
         2'd0: begin
            for (int ch = 0; ch < 3; ch++) cnum[ch] = 10'(cur_ff.color0[ch]);
         end
         2'd1: begin
            for (int ch = 0; ch < 3; ch++) cnum[ch] = 10'(cur_ff.color1[ch]);
         end
         2'd2: begin
            if (cur_ff.color_greater) begin
               cop = bc3_pkg::COP_DIV3;
               for (int ch = 0; ch < 3; ch++) begin
                  cnum[ch] = {1'b0, cur_ff.color0[ch], 1'b0} + 10'(cur_ff.color1[ch]);
               end
            end else begin
               cop = bc3_pkg::COP_DIV2;
               for (int ch = 0; ch < 3; ch++) begin
                  cnum[ch] = 10'(cur_ff.color0[ch]) + 10'(cur_ff.color1[ch]);
               end
            end
         end
         2'd3: begin
            if (cur_ff.color_greater) begin
               cop = bc3_pkg::COP_DIV3;
               for (int ch = 0; ch < 3; ch++) begin
                  cnum[ch] = 10'(cur_ff.color0[ch]) + {1'b0, cur_ff.color1[ch], 1'b0};
               end
            end else begin
               for (int ch = 0; ch < 3; ch++) cnum[ch] = '0;
            end
         end
         default: begin
            for (int ch = 0; ch < 3; ch++) cnum[ch] = '0;
         end
      endcase
   end

   assign a_valid_in   = a_free ? issue : a_valid_ff;
   assign out_valid_in = load_b ? a_valid_ff : out_valid_ff;

   // divide by constants into the output register
   always_comb begin
      unique case (a_aop_ff)
         bc3_pkg::AOP_PASS: alpha = a_anum_ff[7:0];
         bc3_pkg::AOP_DIV7: alpha = bc3_pkg::div7(a_anum_ff);
         bc3_pkg::AOP_DIV5: alpha = bc3_pkg::div5(a_anum_ff);
         default:           alpha = a_anum_ff[7:0];
      endcase
      for (int ch = 0; ch < 3; ch++) begin
         unique case (a_cop_ff)
            bc3_pkg::COP_PASS: rgb[ch] = a_cnum_ff[ch][7:0];
            bc3_pkg::COP_DIV3: rgb[ch] = bc3_pkg::div3(a_cnum_ff[ch]);
            bc3_pkg::COP_DIV2: rgb[ch] = a_cnum_ff[ch][8:1];
            default:           rgb[ch] = a_cnum_ff[ch][7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rem_ff <= rem_in;
      if (issue) begin
         a_px_ff   <= {cur_ff.block_column, texel[1:0]};
         a_py_ff   <= {cur_ff.block_row, texel[3:2]};
         a_last_ff <= rem_after == '0;
         a_anum_ff <= anum;
         a_aop_ff  <= aop;
         a_cnum_ff <= cnum;
         a_cop_ff  <= cop;
      end
      if (load_b && a_valid_ff) begin
         out_px_ff    <= a_px_ff;
         out_py_ff    <= a_py_ff;
         out_rgb_ff   <= rgb;
         out_alpha_ff <= alpha;
         out_last_ff  <= a_last_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.pixel_x     = out_px_ff;
   assign rsp.pixel_y     = out_py_ff;
   assign rsp.red         = out_rgb_ff[2];
   assign rsp.green       = out_rgb_ff[1];
   assign rsp.blue        = out_rgb_ff[0];
   assign rsp.alpha_value = out_alpha_ff;
   assign rsp.last_texel  = out_last_ff;

endmodule

// File: src/bc3_texture_block_decoder.sv
// channel  direction  transfer carries
// req_bus  in         block_low, block_high, block_column, block_row
// rsp_bus  out        pixel_x, pixel_y, red, green, blue, alpha_value, last_texel
// csr      in         csr_index 0 image_width, 1 image_height; write only
//
// One texel leaves per cycle while rsp_bus is not stalled. The back-end sequencer
// issues each texel of a block inside the image, loading the next block with the
// last; the front drops wholly clipped blocks. A texel passes queue, sequencer,
// palette stage and output register. Two blocks queue between front and back.
// Synchronous active-high reset; sizes come up as 16384, no clearing pass.
// A stalled rsp_bus holds its texel; the front takes blocks until the queue is full.
module bc3_texture_block_decoder #(
   parameter int MAX_DIMENSION = bc3_pkg::MaxDimension
) (
   input  logic                         clock,
   input  logic                         reset,
   bc3_req_if.sink                      req_bus,
   bc3_rsp_if.source                    rsp_bus,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [bc3_pkg::DimRegW-1:0]  csr_write_data
);

   logic                   push_valid, push_ready;
   bc3_pkg::bc3_entry_type push_entry;
   logic                   pop_valid, pop_ready;
   bc3_pkg::bc3_entry_type pop_entry;

   bc3_front #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   bc3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   bc3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp       (rsp_bus)
   );

endmodule

// File: src/bc3_checker.sv
`include "bc3_texture_block_decoder_assert.svh"

module bc3_checker #(
   parameter int MAX_DIMENSION = bc3_pkg::MaxDimension
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        csr_write_enable,
   input logic                        csr_index,
   input logic [bc3_pkg::DimRegW-1:0] csr_write_data,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [13:0]                 pixel_x,
   input logic [13:0]                 pixel_y,
   input logic [7:0]                  red,
   input logic [7:0]                  green,
   input logic [7:0]                  blue,
   input logic [7:0]                  alpha_value,
   input logic                        last_texel
);

   localparam int LimW = $clog2(MAX_DIMENSION + 1);
   localparam int DimW = (LimW > bc3_pkg::DimRegW) ? LimW : bc3_pkg::DimRegW;
   localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIMENSION);

   logic [bc3_pkg::DimRegW-1:0] width_ff, height_ff;
   logic [DimW-1:0] width_lim, height_lim;
   logic stalled;
   logic [60:0] rsp_payload;
   logic rsp_in_image;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bc3_pkg::DimReset;
         height_ff <= bc3_pkg::DimReset;
      end else if (csr_write_enable) begin
         if (csr_index == bc3_pkg::RegImageWidth) begin
            width_ff <= csr_write_data;
         end else begin
            height_ff <= csr_write_data;
         end
      end
   end

   assign width_lim  = (DimW'(width_ff) > MaxDim) ? MaxDim : DimW'(width_ff);
   assign height_lim = (DimW'(height_ff) > MaxDim) ? MaxDim : DimW'(height_ff);
   assign stalled    = rsp_valid && !rsp_ready;
   assign rsp_payload = {pixel_x, pixel_y, red, green, blue, alpha_value, last_texel};
   assign rsp_in_image = (DimW'(pixel_x) < width_lim) && (DimW'(pixel_y) < height_lim);

   `BC3_ASSERT_NXT(a_rsp_held, clock, reset, stalled, rsp_valid)

   `BC3_ASSERT_NXT(a_rsp_stable, clock, reset, stalled, $stable(rsp_payload))

   `BC3_ASSERT_IMP(a_texel_clipped, clock, reset, rsp_valid, rsp_in_image)

   `BC3_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind bc3_texture_block_decoder bc3_checker #(
   .MAX_DIMENSION(MAX_DIMENSION)
) u_bc3_checker (
   .clock            (clock),
   .reset            (reset),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index),
   .csr_write_data   (csr_write_data),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .pixel_x          (rsp_bus.pixel_x),
   .pixel_y          (rsp_bus.pixel_y),
   .red              (rsp_bus.red),
   .green            (rsp_bus.green),
   .blue             (rsp_bus.blue),
   .alpha_value      (rsp_bus.alpha_value),
   .last_texel       (rsp_bus.last_texel)
);
